[hdl/rlec_pkg.sv]
// Shared types and constants for the RGB LED effect controller.
`default_nettype none

package rlec_pkg;

    // Width of a channel level and of a tenths value (0 to 10)
    localparam int LEVEL_W  = 8;
    localparam int TENTHS_W = 4;
    localparam int PROD_W   = LEVEL_W + TENTHS_W;

    // Bit-serial scaler: one step per multiplier bit, one per product bit
    localparam int MUL_STEPS   = TENTHS_W;
    localparam int SCALE_STEPS = MUL_STEPS + PROD_W;
    localparam int STEP_W      = $clog2(SCALE_STEPS);
    localparam int REM_W       = 4;

    localparam logic [TENTHS_W-1:0] FULL_TENTHS = 4'd10;

    // Remote button codes
    localparam logic [31:0] CODE_NEXT      = 32'h00FD609F;
    localparam logic [31:0] CODE_PREV      = 32'h00FD20DF;
    localparam logic [31:0] CODE_BRIGHT_UP = 32'h00FD906F;
    localparam logic [31:0] CODE_BRIGHT_DN = 32'h00FD807F;
    localparam logic [31:0] CODE_RED_UP    = 32'h00FD08F7;
    localparam logic [31:0] CODE_RED_DN    = 32'h00FD28D7;
    localparam logic [31:0] CODE_GREEN_UP  = 32'h00FD8877;
    localparam logic [31:0] CODE_GREEN_DN  = 32'h00FDA857;
    localparam logic [31:0] CODE_BLUE_UP   = 32'h00FD48B7;
    localparam logic [31:0] CODE_BLUE_DN   = 32'h00FD6897;
    localparam logic [31:0] CODE_ON_OFF    = 32'h00FD00FF;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ON_OFF,
        CMD_PREV,
        CMD_NEXT,
        CMD_BRIGHT_UP,
        CMD_BRIGHT_DN,
        CMD_RED_UP,
        CMD_RED_DN,
        CMD_GREEN_UP,
        CMD_GREEN_DN,
        CMD_BLUE_UP,
        CMD_BLUE_DN
    } cmd_t;

endpackage

`default_nettype wire

[hdl/rlec_decode.sv]
// Remote code decoder: maps a received button code to a command.
`default_nettype none

module rlec_decode (
    input  wire logic          code_valid,
    input  wire logic [31:0]   remote_code,
    output rlec_pkg::cmd_t     cmd
);

    always_comb
    begin
        cmd = rlec_pkg::CMD_NONE;
        if (code_valid)
        begin
            unique case (remote_code)
                rlec_pkg::CODE_ON_OFF:    cmd = rlec_pkg::CMD_ON_OFF;
                rlec_pkg::CODE_PREV:      cmd = rlec_pkg::CMD_PREV;
                rlec_pkg::CODE_NEXT:      cmd = rlec_pkg::CMD_NEXT;
                rlec_pkg::CODE_BRIGHT_UP: cmd = rlec_pkg::CMD_BRIGHT_UP;
                rlec_pkg::CODE_BRIGHT_DN: cmd = rlec_pkg::CMD_BRIGHT_DN;
                rlec_pkg::CODE_RED_UP:    cmd = rlec_pkg::CMD_RED_UP;
                rlec_pkg::CODE_RED_DN:    cmd = rlec_pkg::CMD_RED_DN;
                rlec_pkg::CODE_GREEN_UP:  cmd = rlec_pkg::CMD_GREEN_UP;
                rlec_pkg::CODE_GREEN_DN:  cmd = rlec_pkg::CMD_GREEN_DN;
                rlec_pkg::CODE_BLUE_UP:   cmd = rlec_pkg::CMD_BLUE_UP;
                rlec_pkg::CODE_BLUE_DN:   cmd = rlec_pkg::CMD_BLUE_DN;
                default:                  cmd = rlec_pkg::CMD_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/rlec_scaler.sv]
// Bit-serial scaler lane: floor(level * tenths / 10), one bit per cycle.
`default_nettype none

module rlec_scaler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [rlec_pkg::LEVEL_W-1:0]       level,
    input  wire logic [rlec_pkg::TENTHS_W-1:0]      tenths,
    output logic                                    done,
    output logic [rlec_pkg::LEVEL_W-1:0]            result
);

    logic                               busy_reg,   busy_next;
    logic                               done_reg,   done_next;
    logic [rlec_pkg::STEP_W-1:0]        step_reg,   step_next;
    logic [rlec_pkg::PROD_W-1:0]        mcand_reg,  mcand_next;
    logic [rlec_pkg::TENTHS_W-1:0]      mplier_reg, mplier_next;
    logic [rlec_pkg::PROD_W-1:0]        acc_reg,    acc_next;
    logic [rlec_pkg::REM_W-1:0]         rem_reg,    rem_next;
    logic [rlec_pkg::REM_W:0]           rem_shift;
    logic                               q_bit;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        rem_shift   = {rem_reg, acc_reg[rlec_pkg::PROD_W-1]};
        q_bit       = (rem_shift >= (rlec_pkg::REM_W+1)'(rlec_pkg::FULL_TENTHS));

        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            mcand_next  = rlec_pkg::PROD_W'(level);
            mplier_next = tenths;
            acc_next    = '0;
            rem_next    = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < rlec_pkg::STEP_W'(rlec_pkg::MUL_STEPS))
            begin
                // shift-add multiply, multiplier LSB first
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[rlec_pkg::PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[rlec_pkg::TENTHS_W-1:1]};
            end
            else
            begin
                // restoring divide by ten, product MSB first
                if (q_bit)
                begin
                    rem_next = rlec_pkg::REM_W'(rem_shift
                               - (rlec_pkg::REM_W+1)'(rlec_pkg::FULL_TENTHS));
                end
                else
                begin
                    rem_next = rem_shift[rlec_pkg::REM_W-1:0];
                end
                acc_next = {acc_reg[rlec_pkg::PROD_W-2:0], q_bit};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == rlec_pkg::STEP_W'(rlec_pkg::SCALE_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg[rlec_pkg::LEVEL_W-1:0];

endmodule

`default_nettype wire

[hdl/rgb_led_effect_controller.sv]
// Top level of the RGB LED effect controller: control, effect state, scaler lanes.
`default_nettype none

//  Channel   Signals                                   Direction  Transaction
//  -------   ---------------------------------------   ---------  ---------------------
//  in        in_valid/in_ready, code_valid,            input      one animation tick
//            remote_code
//  out       out_valid/out_ready, red_duty,            output     one set of pwm duties
//            green_duty, blue_duty, current_mode,
//            lamp_is_on
//  cfg       cfg_we, cfg_wdata                         input      fade_step write
//
// A tick passes through the 16-step bit-serial scaler lanes: one gain pass for fade and
// static mode, then one brightness pass for every mode. No new tick is accepted until
// the duties of the last one are loaded into the output register.
// A stalled output only delays the final load into the output register.
// Reset (rst_n low, asynchronous) restores lamp on, rainbow mode, full brightness and
// gains, levels 255, and fade_step 13; the block is ready right after reset.

module rgb_led_effect_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           code_valid,
    input  wire logic [31:0]    remote_code,

    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          red_duty,
    output logic [7:0]          green_duty,
    output logic [7:0]          blue_duty,
    output logic [1:0]          current_mode,
    output logic                lamp_is_on,

    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_wdata
);

    localparam int NUM_CH = 3;
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [rlec_pkg::LEVEL_W-1:0] LEVEL_FULL   = 8'd255;
    localparam logic [rlec_pkg::LEVEL_W-1:0] RAINBOW_STEP = 8'd5;
    localparam logic [7:0]                   FADE_STEP_RESET = 8'd13;

    typedef enum logic [1:0] {
        MODE_RAINBOW = 2'd0,
        MODE_FADE    = 2'd1,
        MODE_STATIC  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_RED_GREEN,
        PH_GREEN_BLUE,
        PH_BLUE_RED
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EFFECT,
        S_GAIN,
        S_BRIGHT_GO,
        S_BRIGHT,
        S_OUT
    } state_t;

    // Control state
    state_t     state_reg,        state_next;
    logic       out_valid_reg,    out_valid_next;

    // Effect state
    logic [7:0]                         fade_step_reg,    fade_step_next;
    mode_t                              light_mode_reg,   light_mode_next;
    logic                               lamp_on_reg,      lamp_on_next;
    logic [rlec_pkg::TENTHS_W-1:0]      bright_reg,       bright_next;
    logic [rlec_pkg::TENTHS_W-1:0]      gain_reg  [NUM_CH];
    logic [rlec_pkg::TENTHS_W-1:0]      gain_next [NUM_CH];
    logic [rlec_pkg::LEVEL_W-1:0]       level_reg  [NUM_CH];
    logic [rlec_pkg::LEVEL_W-1:0]       level_next [NUM_CH];
    phase_t                             phase_reg,        phase_next;
    logic [rlec_pkg::LEVEL_W-1:0]       fade_level_reg,   fade_level_next;
    logic                               fade_falling_reg, fade_falling_next;

    // Output register
    logic [rlec_pkg::LEVEL_W-1:0]       duty_reg  [NUM_CH];
    logic [rlec_pkg::LEVEL_W-1:0]       duty_next [NUM_CH];
    logic [1:0]                         mode_out_reg,     mode_out_next;
    logic                               lamp_out_reg,     lamp_out_next;

    // Lanes
    logic                               lane_start;
    logic [NUM_CH-1:0]                  lane_done;
    logic [rlec_pkg::LEVEL_W-1:0]       lane_level  [NUM_CH];
    logic [rlec_pkg::TENTHS_W-1:0]      lane_tenths [NUM_CH];
    logic [rlec_pkg::LEVEL_W-1:0]       lane_result [NUM_CH];

    // Effect helpers
    rlec_pkg::cmd_t                     cmd;
    logic                               in_xact;
    logic [1:0]                         down_idx;
    logic [1:0]                         up_idx;
    phase_t                             cross_phase;
    logic [rlec_pkg::LEVEL_W-1:0]       down_val;
    logic [rlec_pkg::LEVEL_W:0]         up_sum;
    logic [rlec_pkg::LEVEL_W-1:0]       up_val;
    logic [rlec_pkg::LEVEL_W:0]         fade_sum;
    logic [rlec_pkg::LEVEL_W-1:0]       fade_new;
    logic                               fade_fall_new;
    logic [rlec_pkg::LEVEL_W-1:0]       gain_base;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xact  = in_valid && in_ready;

    rlec_decode u_decode (
        .code_valid  (code_valid),
        .remote_code (remote_code),
        .cmd         (cmd)
    );

    // Fade level advance with bounce at both ends
    always_comb
    begin
        fade_sum      = {1'b0, fade_level_reg} + {1'b0, fade_step_reg};
        fade_new      = fade_level_reg;
        fade_fall_new = fade_falling_reg;
        if (!fade_falling_reg)
        begin
            if (fade_sum > {1'b0, LEVEL_FULL})
            begin
                fade_new      = LEVEL_FULL;
                fade_fall_new = 1'b1;
            end
            else
            begin
                fade_new = fade_sum[rlec_pkg::LEVEL_W-1:0];
            end
        end
        else
        begin
            if (fade_step_reg > fade_level_reg)
            begin
                fade_new      = '0;
                fade_fall_new = 1'b0;
            end
            else
            begin
                fade_new = fade_level_reg - fade_step_reg;
            end
        end
        // static mode scales full level; fade scales the inverted fade level
        gain_base = (light_mode_reg == MODE_FADE) ? (LEVEL_FULL - fade_new) : LEVEL_FULL;
    end

    // Rainbow crossfade: pick falling and rising channel from the phase
    always_comb
    begin
        unique case (phase_reg)
            PH_RED_GREEN:
            begin
                down_idx    = CH_RED;
                up_idx      = CH_GREEN;
                cross_phase = PH_GREEN_BLUE;
            end
            PH_GREEN_BLUE:
            begin
                down_idx    = CH_GREEN;
                up_idx      = CH_BLUE;
                cross_phase = PH_BLUE_RED;
            end
            PH_BLUE_RED:
            begin
                down_idx    = CH_BLUE;
                up_idx      = CH_RED;
                cross_phase = PH_RED_GREEN;
            end
            default:
            begin
                down_idx    = CH_RED;
                up_idx      = CH_GREEN;
                cross_phase = PH_RED_GREEN;
            end
        endcase
        down_val = (level_reg[down_idx] >= RAINBOW_STEP) ?
                   (level_reg[down_idx] - RAINBOW_STEP) : '0;
        up_sum   = {1'b0, level_reg[up_idx]} + {1'b0, RAINBOW_STEP};
        up_val   = (up_sum > {1'b0, LEVEL_FULL}) ?
                   LEVEL_FULL : up_sum[rlec_pkg::LEVEL_W-1:0];
    end

    // Lane operands: gain pass starts from the effect step, brightness pass afterwards
    always_comb
    begin
        lane_start = ((state_reg == S_EFFECT) &&
                      ((light_mode_reg == MODE_FADE) || (light_mode_reg == MODE_STATIC)))
                     || (state_reg == S_BRIGHT_GO);
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (state_reg == S_BRIGHT_GO)
            begin
                lane_level[i]  = level_reg[i];
                lane_tenths[i] = bright_reg;
            end
            else
            begin
                lane_level[i]  = gain_base;
                lane_tenths[i] = gain_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        rlec_scaler u_scaler (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start),
            .level  (lane_level[g]),
            .tenths (lane_tenths[g]),
            .done   (lane_done[g]),
            .result (lane_result[g])
        );
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        fade_step_next    = fade_step_reg;
        light_mode_next   = light_mode_reg;
        lamp_on_next      = lamp_on_reg;
        bright_next       = bright_reg;
        phase_next        = phase_reg;
        fade_level_next   = fade_level_reg;
        fade_falling_next = fade_falling_reg;
        mode_out_next     = mode_out_reg;
        lamp_out_next     = lamp_out_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            gain_next[i]  = gain_reg[i];
            level_next[i] = level_reg[i];
            duty_next[i]  = duty_reg[i];
        end

        if (cfg_we)
        begin
            fade_step_next = cfg_wdata;
        end

        // drop the output transaction once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = S_EFFECT;
                    unique case (cmd)
                        rlec_pkg::CMD_ON_OFF:
                        begin
                            lamp_on_next = ~lamp_on_reg;
                        end
                        rlec_pkg::CMD_PREV, rlec_pkg::CMD_NEXT:
                        begin
                            if (cmd == rlec_pkg::CMD_PREV)
                            begin
                                unique case (light_mode_reg)
                                    MODE_RAINBOW: light_mode_next = MODE_STATIC;
                                    MODE_FADE:    light_mode_next = MODE_RAINBOW;
                                    MODE_STATIC:  light_mode_next = MODE_FADE;
                                    default:      light_mode_next = MODE_STATIC;
                                endcase
                            end
                            else
                            begin
                                unique case (light_mode_reg)
                                    MODE_RAINBOW: light_mode_next = MODE_FADE;
                                    MODE_FADE:    light_mode_next = MODE_STATIC;
                                    MODE_STATIC:  light_mode_next = MODE_RAINBOW;
                                    default:      light_mode_next = MODE_RAINBOW;
                                endcase
                            end
                            // restore defaults except the mode
                            lamp_on_next      = 1'b1;
                            bright_next       = rlec_pkg::FULL_TENTHS;
                            phase_next        = PH_START;
                            fade_level_next   = '0;
                            fade_falling_next = 1'b0;
                            for (int i = 0; i < NUM_CH; i++)
                            begin
                                gain_next[i]  = rlec_pkg::FULL_TENTHS;
                                level_next[i] = LEVEL_FULL;
                            end
                        end
                        rlec_pkg::CMD_BRIGHT_UP:
                        begin
                            if (bright_reg < rlec_pkg::FULL_TENTHS)
                                bright_next = bright_reg + 1'b1;
                        end
                        rlec_pkg::CMD_BRIGHT_DN:
                        begin
                            if (bright_reg != '0)
                                bright_next = bright_reg - 1'b1;
                        end
                        rlec_pkg::CMD_RED_UP:
                        begin
                            if (gain_reg[CH_RED] < rlec_pkg::FULL_TENTHS)
                                gain_next[CH_RED] = gain_reg[CH_RED] + 1'b1;
                        end
                        rlec_pkg::CMD_RED_DN:
                        begin
                            if (gain_reg[CH_RED] != '0)
                                gain_next[CH_RED] = gain_reg[CH_RED] - 1'b1;
                        end
                        rlec_pkg::CMD_GREEN_UP:
                        begin
                            if (gain_reg[CH_GREEN] < rlec_pkg::FULL_TENTHS)
                                gain_next[CH_GREEN] = gain_reg[CH_GREEN] + 1'b1;
                        end
                        rlec_pkg::CMD_GREEN_DN:
                        begin
                            if (gain_reg[CH_GREEN] != '0)
                                gain_next[CH_GREEN] = gain_reg[CH_GREEN] - 1'b1;
                        end
                        rlec_pkg::CMD_BLUE_UP:
                        begin
                            if (gain_reg[CH_BLUE] < rlec_pkg::FULL_TENTHS)
                                gain_next[CH_BLUE] = gain_reg[CH_BLUE] + 1'b1;
                        end
                        rlec_pkg::CMD_BLUE_DN:
                        begin
                            if (gain_reg[CH_BLUE] != '0)
                                gain_next[CH_BLUE] = gain_reg[CH_BLUE] - 1'b1;
                        end
                        default:
                        begin
                            // no code, or an unknown one: hold everything
                        end
                    endcase
                end
            end

            S_EFFECT:
            begin
                unique case (light_mode_reg)
                    MODE_RAINBOW:
                    begin
                        state_next = S_BRIGHT_GO;
                        if (phase_reg == PH_START)
                        begin
                            level_next[CH_RED]   = LEVEL_FULL;
                            level_next[CH_GREEN] = '0;
                            level_next[CH_BLUE]  = '0;
                            phase_next           = PH_RED_GREEN;
                        end
                        else
                        begin
                            level_next[down_idx] = down_val;
                            level_next[up_idx]   = up_val;
                            if (up_val == LEVEL_FULL)
                                phase_next = cross_phase;
                        end
                    end
                    MODE_FADE:
                    begin
                        // lanes start this cycle on the new fade level
                        fade_level_next   = fade_new;
                        fade_falling_next = fade_fall_new;
                        state_next        = S_GAIN;
                    end
                    MODE_STATIC:
                    begin
                        state_next = S_GAIN;
                    end
                    default:
                    begin
                        // unreachable mode: levels hold
                        state_next = S_BRIGHT_GO;
                    end
                endcase
            end

            S_GAIN:
            begin
                // all lanes start together, so they finish together
                if (&lane_done)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        level_next[i] = lane_result[i];
                    end
                    state_next = S_BRIGHT_GO;
                end
            end

            S_BRIGHT_GO:
            begin
                state_next = S_BRIGHT;
            end

            S_BRIGHT:
            begin
                if (&lane_done)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // load the output register once it is free or being taken
                if (!out_valid_reg || out_ready)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        duty_next[i] = lamp_on_reg ? lane_result[i] : '0;
                    end
                    mode_out_next  = light_mode_reg;
                    lamp_out_next  = lamp_on_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            fade_step_reg    <= FADE_STEP_RESET;
            light_mode_reg   <= MODE_RAINBOW;
            lamp_on_reg      <= 1'b1;
            bright_reg       <= rlec_pkg::FULL_TENTHS;
            phase_reg        <= PH_START;
            fade_level_reg   <= '0;
            fade_falling_reg <= 1'b0;
            mode_out_reg     <= '0;
            lamp_out_reg     <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                gain_reg[i]  <= rlec_pkg::FULL_TENTHS;
                level_reg[i] <= LEVEL_FULL;
                duty_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            fade_step_reg    <= fade_step_next;
            light_mode_reg   <= light_mode_next;
            lamp_on_reg      <= lamp_on_next;
            bright_reg       <= bright_next;
            phase_reg        <= phase_next;
            fade_level_reg   <= fade_level_next;
            fade_falling_reg <= fade_falling_next;
            mode_out_reg     <= mode_out_next;
            lamp_out_reg     <= lamp_out_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                gain_reg[i]  <= gain_next[i];
                level_reg[i] <= level_next[i];
                duty_reg[i]  <= duty_next[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_duty     = duty_reg[CH_RED];
    assign green_duty   = duty_reg[CH_GREEN];
    assign blue_duty    = duty_reg[CH_BLUE];
    assign current_mode = mode_out_reg;
    assign lamp_is_on   = lamp_out_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the RGB LED effect controller: directed ticks, then random runs.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int TAIL_CYCLES     = 64;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 100;
    localparam int FADE_STEP_RESET = 13;

    localparam logic [7:0] RAINBOW_STEP = 8'd5;
    localparam logic [7:0] FULL_LEVEL   = 8'd255;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {MODE_RAINBOW, MODE_FADE, MODE_STATIC} light_mode_e;
    typedef enum logic [1:0] {RB_START, RB_RED_GREEN, RB_GREEN_BLUE, RB_BLUE_RED} rb_phase_e;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;
    typedef enum logic [1:0] {RUN_PLAIN, RUN_STEP, RUN_SINGLE, RUN_NOISE} run_kind_e;

    // One set of pwm duties as the block reports it
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        light_mode_e mode;
        logic        lamp;
    } duty_set_t;

    // One row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic        cv;
        logic [31:0] code;
        logic        typed;
        duty_set_t   want;
    } tick_row_t;

    // DUT ports; every input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        code_valid  = 1'b0;
    logic [31:0] remote_code = 32'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  red_duty;
    logic [7:0]  green_duty;
    logic [7:0]  blue_duty;
    logic [1:0]  current_mode;
    logic        lamp_is_on;
    logic        cfg_we      = 1'b0;
    logic [7:0]  cfg_wdata   = 8'd0;

    // Shadow copy of the controller state, advanced once per accepted tick
    logic [7:0]  fade_step_q;
    light_mode_e mode_q;
    logic        lamp_q;
    logic [3:0]  bright_q;
    logic [3:0]  gain_q [3];
    logic [7:0]  level_q [3];
    rb_phase_e   phase_q;
    logic [7:0]  fade_lvl_q;
    logic        fade_down_q;

    // Duty sets predicted for accepted ticks, oldest first
    duty_set_t   pending_duties [$];
    duty_set_t   want_duty;
    tick_row_t   directed_rows [$];

    int unsigned mismatches   = 0;
    int unsigned result_idx   = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct    = 0;

    // Long receiver hold-off: the stimulus flips the toggle, the receiver counts
    logic        holdoff_toggle = 1'b0;
    logic        holdoff_seen   = 1'b0;
    int unsigned holdoff_left   = 0;

    // State of the random run generator
    run_kind_e   run_kind = RUN_PLAIN;
    int unsigned run_left = 0;
    logic [31:0] run_code = 32'd0;

    logic [31:0] step_codes [8] = '{rlec_pkg::CODE_BRIGHT_UP, rlec_pkg::CODE_BRIGHT_DN,
                                    rlec_pkg::CODE_RED_UP, rlec_pkg::CODE_RED_DN,
                                    rlec_pkg::CODE_GREEN_UP, rlec_pkg::CODE_GREEN_DN,
                                    rlec_pkg::CODE_BLUE_UP, rlec_pkg::CODE_BLUE_DN};
    logic [31:0] ctrl_codes [3] = '{rlec_pkg::CODE_ON_OFF, rlec_pkg::CODE_NEXT,
                                    rlec_pkg::CODE_PREV};

    rgb_led_effect_controller i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_valid   (code_valid),
        .remote_code  (remote_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty),
        .current_mode (current_mode),
        .lamp_is_on   (lamp_is_on),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Duty predictor
    // ------------------------------------------------------------------

    // Multiply by tenths and truncate, as every scaling stage does
    function automatic logic [7:0] scale_tenths(input logic [7:0] lvl, input logic [3:0] t);
        int unsigned prod;
        prod = int'(lvl) * int'(t);
        return 8'(prod / int'(rlec_pkg::FULL_TENTHS));
    endfunction

    function automatic logic [3:0] tenths_up(input logic [3:0] t);
        return (t < rlec_pkg::FULL_TENTHS) ? t + 4'd1 : t;
    endfunction

    function automatic logic [3:0] tenths_down(input logic [3:0] t);
        return (t > 4'd0) ? t - 4'd1 : t;
    endfunction

    // Everything a mode change puts back; the mode and fade step survive
    function automatic void restore_defaults();
        lamp_q      = 1'b1;
        bright_q    = rlec_pkg::FULL_TENTHS;
        phase_q     = RB_START;
        fade_lvl_q  = 8'd0;
        fade_down_q = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            gain_q[c]  = rlec_pkg::FULL_TENTHS;
            level_q[c] = FULL_LEVEL;
        end
    endfunction

    // Move one rainbow step from the falling channel into the rising one
    function automatic void crossfade(input int fall, input int rise, input rb_phase_e nxt);
        level_q[fall] = (level_q[fall] >= RAINBOW_STEP) ? level_q[fall] - RAINBOW_STEP : 8'd0;
        level_q[rise] = (level_q[rise] >= FULL_LEVEL - RAINBOW_STEP) ?
                        FULL_LEVEL : level_q[rise] + RAINBOW_STEP;
        if (level_q[rise] == FULL_LEVEL)
            phase_q = nxt;
    endfunction

    function automatic void reset_model();
        fade_step_q = 8'(FADE_STEP_RESET);
        mode_q      = MODE_RAINBOW;
        restore_defaults();
    endfunction

    // Handle the code, advance the effect, and return the duties of this tick
    function automatic duty_set_t compute_duties(input logic cv, input logic [31:0] code);
        duty_set_t   d;
        logic [7:0]  base;
        if (cv)
        begin
            case (code)
                rlec_pkg::CODE_ON_OFF:    lamp_q = ~lamp_q;
                rlec_pkg::CODE_PREV:
                begin
                    case (mode_q)
                        MODE_FADE:   mode_q = MODE_RAINBOW;
                        MODE_STATIC: mode_q = MODE_FADE;
                        default:     mode_q = MODE_STATIC;
                    endcase
                    restore_defaults();
                end
                rlec_pkg::CODE_NEXT:
                begin
                    case (mode_q)
                        MODE_RAINBOW: mode_q = MODE_FADE;
                        MODE_FADE:    mode_q = MODE_STATIC;
                        default:      mode_q = MODE_RAINBOW;
                    endcase
                    restore_defaults();
                end
                rlec_pkg::CODE_BRIGHT_UP: bright_q = tenths_up(bright_q);
                rlec_pkg::CODE_BRIGHT_DN: bright_q = tenths_down(bright_q);
                rlec_pkg::CODE_RED_UP:    gain_q[CH_RED] = tenths_up(gain_q[CH_RED]);
                rlec_pkg::CODE_RED_DN:    gain_q[CH_RED] = tenths_down(gain_q[CH_RED]);
                rlec_pkg::CODE_GREEN_UP:  gain_q[CH_GREEN] = tenths_up(gain_q[CH_GREEN]);
                rlec_pkg::CODE_GREEN_DN:  gain_q[CH_GREEN] = tenths_down(gain_q[CH_GREEN]);
                rlec_pkg::CODE_BLUE_UP:   gain_q[CH_BLUE] = tenths_up(gain_q[CH_BLUE]);
                rlec_pkg::CODE_BLUE_DN:   gain_q[CH_BLUE] = tenths_down(gain_q[CH_BLUE]);
                default:                  ;
            endcase
        end

        case (mode_q)
            MODE_RAINBOW:
            begin
                case (phase_q)
                    RB_START:
                    begin
                        level_q[CH_RED]   = FULL_LEVEL;
                        level_q[CH_GREEN] = 8'd0;
                        level_q[CH_BLUE]  = 8'd0;
                        phase_q           = RB_RED_GREEN;
                    end
                    RB_RED_GREEN:  crossfade(CH_RED, CH_GREEN, RB_GREEN_BLUE);
                    RB_GREEN_BLUE: crossfade(CH_GREEN, CH_BLUE, RB_BLUE_RED);
                    default:       crossfade(CH_BLUE, CH_RED, RB_RED_GREEN);
                endcase
            end
            MODE_FADE:
            begin
                // Triangle with a bounce at both ends
                if (!fade_down_q)
                begin
                    if (int'(fade_lvl_q) + int'(fade_step_q) > int'(FULL_LEVEL))
                    begin
                        fade_lvl_q  = FULL_LEVEL;
                        fade_down_q = 1'b1;
                    end
                    else
                        fade_lvl_q = fade_lvl_q + fade_step_q;
                end
                else
                begin
                    if (fade_step_q > fade_lvl_q)
                    begin
                        fade_lvl_q  = 8'd0;
                        fade_down_q = 1'b0;
                    end
                    else
                        fade_lvl_q = fade_lvl_q - fade_step_q;
                end
                base = FULL_LEVEL - fade_lvl_q;
                for (int c = 0; c < 3; c++)
                    level_q[c] = scale_tenths(base, gain_q[c]);
            end
            MODE_STATIC:
            begin
                for (int c = 0; c < 3; c++)
                    level_q[c] = scale_tenths(FULL_LEVEL, gain_q[c]);
            end
            default: ;
        endcase

        d.red   = lamp_q ? scale_tenths(level_q[CH_RED], bright_q) : 8'd0;
        d.green = lamp_q ? scale_tenths(level_q[CH_GREEN], bright_q) : 8'd0;
        d.blue  = lamp_q ? scale_tenths(level_q[CH_BLUE], bright_q) : 8'd0;
        d.mode  = mode_q;
        d.lamp  = lamp_q;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    // Row whose result is typed in by hand
    function automatic tick_row_t typed_row(input logic cv, input logic [31:0] code,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input light_mode_e m,
                                            input logic lamp);
        tick_row_t row;
        row.cv         = cv;
        row.code       = code;
        row.typed      = 1'b1;
        row.want.red   = r;
        row.want.green = g;
        row.want.blue  = b;
        row.want.mode  = m;
        row.want.lamp  = lamp;
        return row;
    endfunction

    // Row checked against the predictor
    function automatic tick_row_t free_row(input logic cv, input logic [31:0] code);
        tick_row_t row;
        row       = '0;
        row.cv    = cv;
        row.code  = code;
        row.typed = 1'b0;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick, hold it until the handshake, then queue its duties.
    // Call at a rising edge; return at the edge of acceptance with valid still high.
    task automatic send_tick(input logic cv, input logic [31:0] code,
                             input logic typed, input duty_set_t typed_want);
        duty_set_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_valid  <= cv;
        remote_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = compute_duties(cv, code);
        pending_duties.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid and hold until every queued duty set has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
    endtask

    // Write the fade step; only while the block is idle
    task automatic write_fade_step(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        fade_step_q = value;
    endtask

    task automatic set_idling(input idling_e mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_BOTH) ? 29 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 29 : 0;
    endtask

    // Random ticks come in runs: plain animation ticks, repeated step codes,
    // single on/off or mode codes, and noise (real codes with valid low,
    // or codes one bit away from a real one)
    task automatic pick_random_tick(output logic cv, output logic [31:0] code);
        int unsigned roll;
        if (run_left == 0)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                run_kind = RUN_PLAIN;
                // Long runs let the rainbow and fade cycles wrap around
                run_left = ($urandom_range(9) == 0) ? $urandom_range(60, 170)
                                                    : $urandom_range(1, 20);
            end
            else if (roll < 70)
            begin
                run_kind = RUN_STEP;
                run_code = step_codes[$urandom_range(7)];
                run_left = $urandom_range(1, 12);
            end
            else if (roll < 88)
            begin
                run_kind = RUN_SINGLE;
                run_code = ctrl_codes[$urandom_range(2)];
                run_left = 1;
            end
            else
            begin
                run_kind = RUN_NOISE;
                run_left = $urandom_range(1, 4);
            end
        end
        run_left--;
        case (run_kind)
            RUN_PLAIN:
            begin
                cv   = 1'($urandom_range(1));
                code = $urandom;
            end
            RUN_NOISE:
            begin
                cv   = 1'($urandom_range(1));
                code = $urandom_range(1) ? step_codes[$urandom_range(7)]
                                         : ctrl_codes[$urandom_range(2)];
                if (cv)
                    code = code ^ (32'd1 << $urandom_range(31));
            end
            default:
            begin
                cv   = 1'b1;
                code = run_code;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall at random, or hold off for a long stretch when asked
    always @(posedge clk)
    begin
        if (holdoff_toggle != holdoff_seen)
        begin
            holdoff_seen = holdoff_toggle;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, result_idx, msg);
        mismatches++;
    endtask

    // Compare every accepted duty set with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_duties.size() == 0)
                report_mismatch("duty set with no tick waiting for it");
            else
            begin
                want_duty = pending_duties.pop_front();
                if (red_duty !== want_duty.red)
                    report_mismatch($sformatf("red_duty %0d, expected %0d",
                                              red_duty, want_duty.red));
                if (green_duty !== want_duty.green)
                    report_mismatch($sformatf("green_duty %0d, expected %0d",
                                              green_duty, want_duty.green));
                if (blue_duty !== want_duty.blue)
                    report_mismatch($sformatf("blue_duty %0d, expected %0d",
                                              blue_duty, want_duty.blue));
                if (current_mode !== want_duty.mode)
                    report_mismatch($sformatf("current_mode %0d, expected %0d",
                                              current_mode, want_duty.mode));
                if (lamp_is_on !== want_duty.lamp)
                    report_mismatch($sformatf("lamp_is_on %0d, expected %0d",
                                              lamp_is_on, want_duty.lamp));
            end
            result_idx++;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        logic        cv;
        logic [31:0] code;
        tick_row_t   row;
        logic [7:0]  step_val;

        // Directed ticks, all at the reset fade step of 13
        // Code with valid low is ignored; the rainbow start loads full red
        directed_rows.push_back(typed_row(1'b0, rlec_pkg::CODE_ON_OFF, 8'd255, 8'd0, 8'd0,
                                          MODE_RAINBOW, 1'b1));
        // Unknown code, all ones; first crossfade step
        directed_rows.push_back(typed_row(1'b1, 32'hFFFF_FFFF, 8'd250, 8'd5, 8'd0,
                                          MODE_RAINBOW, 1'b1));
        // Lamp off blanks every duty
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_ON_OFF, 8'd0, 8'd0, 8'd0,
                                          MODE_RAINBOW, 1'b0));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_ON_OFF));
        // Up steps at the top limit are ignored
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_BRIGHT_UP));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_BRIGHT_DN));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_RED_UP));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_RED_DN));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_GREEN_DN));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_BLUE_DN));
        // Mode change restores defaults; fade starts at 13, so 255 - 13
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_NEXT, 8'd242, 8'd242, 8'd242,
                                          MODE_FADE, 1'b1));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_GREEN_UP));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_BLUE_UP));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_RED_DN));
        directed_rows.push_back(free_row(1'b0, 32'd0));
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_NEXT, 8'd255, 8'd255, 8'd255,
                                          MODE_STATIC, 1'b1));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_BLUE_DN));
        // Next wraps from static back to rainbow
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_NEXT, 8'd255, 8'd0, 8'd0,
                                          MODE_RAINBOW, 1'b1));
        // Previous wraps from rainbow to static, then walks back down
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_PREV, 8'd255, 8'd255, 8'd255,
                                          MODE_STATIC, 1'b1));
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_PREV, 8'd242, 8'd242, 8'd242,
                                          MODE_FADE, 1'b1));
        directed_rows.push_back(typed_row(1'b1, rlec_pkg::CODE_PREV, 8'd255, 8'd0, 8'd0,
                                          MODE_RAINBOW, 1'b1));
        // Unknown codes: all zeros, and a real code with the upper byte set
        directed_rows.push_back(free_row(1'b1, 32'd0));
        directed_rows.push_back(free_row(1'b1, rlec_pkg::CODE_ON_OFF ^ 32'hFF00_0000));

        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(IDLE_NONE);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_tick(row.cv, row.code, row.typed, row.want);
        end

        // Random phases: new fade step and idling each time, block drained first
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       step_val = 8'd255;
                1:       step_val = 8'd1;
                2:       step_val = 8'd0;     // fade level must freeze
                default: step_val = 8'($urandom_range(2, 254));
            endcase
            write_fade_step(step_val);
            set_idling(idling_e'(p % 4));
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Back up the output while ticks keep coming
                if (p == 0 && k == 40)
                    holdoff_toggle = ~holdoff_toggle;
                // Pause the sender until everything has drained
                if (p == 4 && k == 60)
                    wait_drained();
                pick_random_tick(cv, code);
                send_tick(cv, code, 1'b0, '0);
            end
        end

        wait_drained();
        // Watch a little longer for stray duty sets
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hdl/rlec_pkg.sv
hdl/rlec_decode.sv
hdl/rlec_scaler.sv
hdl/rgb_led_effect_controller.sv
tb/tb_top.sv
